/* rtl/dpfm_pkg.sv */
// ---------------------------------------------------------------------------
// dpfm_pkg
// Shared constants for the dual pulse flow meter: register indexes, command
// codes, lock bits, reset values and arithmetic widths.
// ---------------------------------------------------------------------------
package dpfm_pkg;

  // command codes of an input transfer
  localparam logic [1:0] CMD_EDGE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_L = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd5;

  // configuration reset values
  localparam logic [15:0] PPL_RST         = 16'd450;
  localparam logic [15:0] RATE_PERIOD_RST = 16'd100;
  localparam logic [15:0] ZERO_WINDOW_RST = 16'd1000;
  localparam logic [15:0] BOOT_MASK_RST   = 16'd300;
  localparam logic [31:0] IDLE_LIMIT_RST  = 32'd1000;

  // interlock bits
  localparam logic [3:0] LOCK_A_RISE = 4'h1;
  localparam logic [3:0] LOCK_A_FALL = 4'h2;
  localparam logic [3:0] LOCK_B_RISE = 4'h4;
  localparam logic [3:0] LOCK_B_FALL = 4'h8;
  localparam logic [3:0] LOCK_A_BITS = LOCK_A_RISE | LOCK_A_FALL;
  localparam logic [3:0] LOCK_B_BITS = LOCK_B_RISE | LOCK_B_FALL;

  // flow arithmetic: count * 60e6 fits 58 bits, ms * pulses/l fits 48 bits
  localparam logic [31:0] MILLI_LPM_SCALE = 32'd60000000;
  localparam int unsigned NUM_W = 58;
  localparam int unsigned DEN_W = 48;

endpackage

/* rtl/dpfm_div.sv */
// ---------------------------------------------------------------------------
// dpfm_div
// Restoring divider, one quotient bit per cycle. Divides a 58-bit numerator
// by a nonzero 48-bit denominator and pulses done with the full quotient.
// ---------------------------------------------------------------------------
module dpfm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dpfm_pkg::NUM_W-1:0] num,
  input  logic [dpfm_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [dpfm_pkg::NUM_W-1:0] quo
);
  import dpfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one shift-subtract step
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/dual_pulse_flow_meter_core.sv */
// ---------------------------------------------------------------------------
// dual_pulse_flow_meter_core
// Counts qualified edges of two meter pulse lines, keeps a millisecond time
// base and computes flow in millilitres per minute with a shared multiplier
// and an iterative divider.
//
//   channel  ports                                   handshake
//   input    in_command, in_channel, in_rising       in_valid / in_stall
//   result   out_pulse_count, out_flow_milli_lpm,    out_valid / out_stall
//            out_flow_active, out_lock_state,
//            out_capture_enabled
//   config   cfg_we, cfg_index, cfg_wdata            write on cfg_we
//
// Edge, clear and no-op transfers go from ST_IDLE straight to ST_FIN. A tick
// passes ST_TICK; a due rate adds two passes through the shared multiplier
// and, for a nonzero divisor, 58 steps of the one-bit-per-cycle divider.
// One item is in work at a time; in_stall is high until its result is loaded.
// The result register lets the next item in while the last result waits.
// Reset is synchronous: counters, snapshots and state clear, config reloads.
// ---------------------------------------------------------------------------
module dual_pulse_flow_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_channel,
  input  logic        in_rising,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pulse_count,
  output logic [31:0] out_flow_milli_lpm,
  output logic        out_flow_active,
  output logic [3:0]  out_lock_state,
  output logic        out_capture_enabled,
  // configuration port
  input  logic        cfg_we,
  input  logic [dpfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);
  import dpfm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL_N,
    ST_MUL_D,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  // configuration registers
  logic        edge_mode_r;
  logic [15:0] ppl_r;
  logic [15:0] rate_period_r;
  logic [15:0] zero_window_r;
  logic [15:0] boot_mask_r;
  logic [31:0] idle_limit_r;

  // meter state
  state_t      state_r;
  logic [31:0] ms_time_r;
  logic [31:0] count_r;
  logic [31:0] count_rate_r;
  logic [31:0] time_rate_r;
  logic [31:0] time_zero_r;
  logic [31:0] count_zero_r;
  logic [31:0] flow_r;
  logic [3:0]  locks_r;
  logic        wait_b_r;
  logic        enabled_r;
  logic [31:0] last_pulse_r;
  logic        seen_r;

  // rate computation
  logic [31:0]      diff_count_r;
  logic [31:0]      elapsed_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_count_r;
  logic [31:0] out_flow_r;
  logic        out_active_r;
  logic [3:0]  out_lock_r;
  logic        out_enabled_r;

  logic        in_xfer;
  logic        out_load;
  logic [31:0] ms_inc;
  logic [31:0] elapsed;
  logic [31:0] zero_age;
  logic        zero_hit;
  logic [3:0]  lock_kept;
  logic [3:0]  edge_lock;
  logic        take;
  logic [3:0]  lock_nxt;
  logic        wait_b_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        div_start;
  logic        div_done;
  logic [NUM_W-1:0] div_quo;
  logic [31:0] pulse_age;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign ms_inc   = ms_time_r + 32'd1;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mode_r   <= 1'b0;
      ppl_r         <= PPL_RST;
      rate_period_r <= RATE_PERIOD_RST;
      zero_window_r <= ZERO_WINDOW_RST;
      boot_mask_r   <= BOOT_MASK_RST;
      idle_limit_r  <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_MODE:    edge_mode_r   <= cfg_wdata[0];
        REG_PULSES_PER_L: ppl_r         <= cfg_wdata[15:0];
        REG_RATE_PERIOD:  rate_period_r <= cfg_wdata[15:0];
        REG_ZERO_WINDOW:  zero_window_r <= cfg_wdata[15:0];
        REG_BOOT_MASK:    boot_mask_r   <= cfg_wdata[15:0];
        REG_IDLE_LIMIT:   idle_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // edge qualification for both modes
  always_comb begin
    lock_kept  = locks_r & (in_channel ? ~LOCK_A_BITS : ~LOCK_B_BITS);
    edge_lock  = in_channel ? (in_rising ? LOCK_B_RISE : LOCK_B_FALL)
                            : (in_rising ? LOCK_A_RISE : LOCK_A_FALL);
    take       = 1'b0;
    lock_nxt   = locks_r;
    wait_b_nxt = wait_b_r;
    if (enabled_r) begin
      if (edge_mode_r) begin
        lock_nxt = lock_kept | edge_lock;
        take     = ((lock_kept & edge_lock) == 4'h0);
      end else if (!in_rising && (in_channel == wait_b_r)) begin
        take       = 1'b1;
        wait_b_nxt = !wait_b_r;
      end
    end
  end

  // rate and zero window checks
  assign elapsed  = ms_time_r - time_rate_r;
  assign zero_age = ms_time_r - time_zero_r;
  assign zero_hit = (zero_age >= {16'h0, zero_window_r});

  // shared multiplier
  always_comb begin
    if (state_r == ST_MUL_D) begin
      mul_a = elapsed_r;
      mul_b = {16'h0, ppl_r};
    end else begin
      mul_a = diff_count_r;
      mul_b = MILLI_LPM_SCALE;
    end
  end
  assign mul_p = {32'h0, mul_a} * {32'h0, mul_b};

  assign div_start = (state_r == ST_DIV_GO) && (den_r != '0);
  assign pulse_age = ms_time_r - last_pulse_r;

  dpfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer and meter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ms_time_r    <= '0;
      count_r      <= '0;
      count_rate_r <= '0;
      time_rate_r  <= '0;
      time_zero_r  <= '0;
      count_zero_r <= '0;
      flow_r       <= '0;
      locks_r      <= '0;
      wait_b_r     <= 1'b0;
      enabled_r    <= 1'b0;
      last_pulse_r <= '0;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result register fill and drain
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_FIN;
            case (in_command)
              CMD_EDGE: begin
                locks_r  <= lock_nxt;
                wait_b_r <= wait_b_nxt;
                if (take) begin
                  count_r      <= count_r + 32'd1;
                  last_pulse_r <= ms_time_r;
                  seen_r       <= 1'b1;
                end
              end
              CMD_TICK: begin
                ms_time_r <= ms_inc;
                if (ms_inc >= {16'h0, boot_mask_r}) begin
                  enabled_r <= 1'b1;
                end
                state_r <= ST_TICK;
              end
              CMD_CLEAR: begin
                count_r      <= '0;
                locks_r      <= '0;
                wait_b_r     <= 1'b0;
                last_pulse_r <= '0;
                seen_r       <= 1'b0;
                count_rate_r <= '0;
                count_zero_r <= '0;
                flow_r       <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          state_r <= ST_FIN;
          if (elapsed >= {16'h0, rate_period_r}) begin
            diff_count_r <= count_r - count_rate_r;
            elapsed_r    <= elapsed;
            count_rate_r <= count_r;
            time_rate_r  <= ms_time_r;
            if (zero_hit) begin
              count_zero_r <= count_r;
              time_zero_r  <= ms_time_r;
            end
            if (zero_hit && (count_r == count_zero_r)) begin
              flow_r <= '0;
            end else if (elapsed != 32'h0) begin
              state_r <= ST_MUL_N;
            end
          end
        end
        ST_MUL_N: begin
          num_r   <= mul_p[NUM_W-1:0];
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          den_r   <= mul_p[DEN_W-1:0];
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          if (den_r == '0) begin
            flow_r  <= (num_r != '0) ? 32'hFFFF_FFFF : 32'h0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            flow_r  <= (div_quo[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // load the result once the register is free
          if (out_load) begin
            out_count_r   <= count_r;
            out_flow_r    <= flow_r;
            out_active_r  <= seen_r && (pulse_age < idle_limit_r);
            out_lock_r    <= edge_mode_r ? locks_r : {3'b000, wait_b_r};
            out_enabled_r <= enabled_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_count     = out_count_r;
  assign out_flow_milli_lpm  = out_flow_r;
  assign out_flow_active     = out_active_r;
  assign out_lock_state      = out_lock_r;
  assign out_capture_enabled = out_enabled_r;

endmodule
